// ----- design/b2da_pkg.sv -----
// shared types, constants and helpers for the binary to decimal ascii converter
package b2da_pkg;

  // field widths
  localparam int VALUE_W        = 64;
  localparam int CHAR_W         = 6;
  localparam int DIGIT_W        = 4;

  // decimal digit slots needed to hold any 64-bit value
  localparam int DIGIT_SLOTS    = 20;
  localparam int BCD_W          = DIGIT_SLOTS * DIGIT_W;
  localparam int CNT_W          = $clog2(DIGIT_SLOTS + 1);
  localparam int BIT_CNT_W      = $clog2(VALUE_W);

  // default digit limit
  localparam int MAX_DIGITS_DEF = 20;

  // ascii code of '0', cut to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } b2da_state_t;

  // commands from the sequencer to the bcd shifter
  typedef struct packed {
    logic load;
    logic dabble;
    logic digit_shift;
  } b2da_ctrl_t;

  // double dabble digit correction: add 3 when the digit is 5 or more
  function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    return r;
  endfunction

endpackage

// ----- design/b2da_bcd_shifter.sv -----
// bcd shift register with per-digit double dabble correction and digit shift-out
module b2da_bcd_shifter
  import b2da_pkg::*;
(
  input  logic                clk,
  input  logic [VALUE_W-1:0]  value,
  input  b2da_ctrl_t          ctrl,
  output logic [DIGIT_W-1:0]  top_digit
);

  logic [VALUE_W-1:0] bin_r;
  logic [VALUE_W-1:0] bin_nxt;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;

  // correct every digit independently before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = add3(bcd_r[i*DIGIT_W +: DIGIT_W]);
    end
  end

  // next value of the binary and bcd registers
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      bin_nxt = value;
      bcd_nxt = '0;
    end else if (ctrl.dabble) begin
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
    end else if (ctrl.digit_shift) begin
      bcd_nxt = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule

// ----- design/binary_to_decimal_ascii.sv -----
// top level: unsigned 64-bit binary to decimal ascii digit stream
//
// Input channel in_valid/in_ready/in_value takes one 64-bit word. The
// result channel out_valid/out_ready carries one ascii digit per word in
// out_digit_char, most significant first, with out_last high on the least
// significant digit. Leading zeros are dropped; zero gives a single '0'.
// Up to MAX_DIGITS (clamped to 1..20) digits are sent, the low ones if longer.
// Operation: after the accept cycle the bit-serial double dabble loop runs,
// one input bit per cycle through the shared bcd shifter. A scan then drops
// one leading digit slot per cycle and settles on the first digit; each
// digit is then held on the output until out_ready takes it. The next word
// can only be accepted after the last digit has been taken.
// in_ready is high only when idle and out of reset: one word at a time.
// A stalled receiver simply holds the current digit in place; the
// conversion waits with it. Synchronous active-low reset returns the
// sequencer to idle and drops out_valid; no other state survives a word.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last
);

  // effective digit limit, clamped to between one and the slot count
  localparam int CAP_I = (MAX_DIGITS > DIGIT_SLOTS) ? DIGIT_SLOTS :
                         (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP_I);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(DIGIT_SLOTS);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT_C = BIT_CNT_W'(VALUE_W - 1);

  b2da_state_t state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic                 seen_r, seen_nxt;

  b2da_ctrl_t           ctrl;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 skip;
  logic                 top_nz;

  assign top_nz = (top_digit != '0);

  // drop a slot while above the limit or while it is a leading zero, never the last slot
  assign skip = (rem_r > CAP_C) ||
                (!seen_r && !top_nz && (rem_r > CNT_W'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == LAST_BIT_C) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!skip) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && (rem_r == CNT_W'(1))) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and shifter commands
  always_comb begin
    ctrl        = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt     = rem_r;
    seen_nxt    = seen_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = rst_n;
        ctrl.load   = in_valid;
        bit_cnt_nxt = '0;
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        rem_nxt     = SLOTS_C;
        seen_nxt    = 1'b0;
      end
      ST_SKIP: begin
        if (skip) begin
          ctrl.digit_shift = 1'b1;
          rem_nxt          = rem_r - CNT_W'(1);
          seen_nxt         = seen_r | top_nz;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctrl.digit_shift = 1'b1;
          rem_nxt          = rem_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      rem_r     <= '0;
      seen_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      rem_r     <= rem_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // shared double dabble unit
  b2da_bcd_shifter u_shifter (
    .clk       (clk),
    .value     (in_value),
    .ctrl      (ctrl),
    .top_digit (top_digit)
  );

  // digit word comes straight from the held top digit
  assign out_digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
  assign out_last       = (rem_r == CNT_W'(1));

endmodule
